// File: hdl/fvc_pkg.sv
// ----------------------------------------------------------------------------
// fvc_pkg: shared types and constants of the forest vote classifier
// Node format, opcodes, sizes and the class-to-label table.
// ----------------------------------------------------------------------------
package fvc_pkg;
   localparam int NUM_TREES     = 100;
   localparam int FEATURE_COUNT = 6;
   localparam int MAX_NODES     = 256;
   localparam int CLASS_COUNT   = 8;

   localparam int TREE_W  = 7;
   localparam int NODE_W  = 8;
   localparam int STORE_DEPTH = NUM_TREES * MAX_NODES;
   localparam int STORE_AW = $clog2(STORE_DEPTH);

   localparam logic [1:0] OP_WRITE_NODE = 2'd0;
   localparam logic [1:0] OP_SET_COUNT  = 2'd1;
   localparam logic [1:0] OP_LOAD_FEAT  = 2'd2;
   localparam logic [1:0] OP_CLASSIFY   = 2'd3;

   localparam logic [2:0] REG_MIN_TWO   = 3'd0;
   localparam logic [2:0] REG_MIN_THREE = 3'd1;
   localparam logic [2:0] REG_MIN_DEF   = 3'd2;
   localparam logic [2:0] REG_LOW_H     = 3'd3;
   localparam logic [2:0] REG_HIGH_H    = 3'd4;
   localparam logic [2:0] REG_SLOW_V    = 3'd5;
   localparam logic [2:0] REG_FAST_V    = 3'd6;
   localparam logic [2:0] REG_GROUND_H  = 3'd7;

   localparam logic [2:0] LABEL_UNKNOWN = 3'd7;

   typedef struct packed {
      logic        leaf;
      logic [2:0]  feat;
      logic [31:0] thr;
      logic [8:0]  left;
      logic [8:0]  right;
      logic [2:0]  cls;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   typedef struct packed {
      logic [7:0]  min_two;
      logic [7:0]  min_three;
      logic [7:0]  min_def;
      logic [11:0] low_h;
      logic [11:0] high_h;
      logic [9:0]  slow_v;
      logic [9:0]  fast_v;
      logic [11:0] ground_h;
   } cfg_type;

   typedef struct packed {
      logic        corr;
      logic [31:0] height;
      logic [30:0] speed;
   } track_type;

   function automatic logic [2:0] class_label(input logic [2:0] cls, input logic unk);
      logic [2:0] r;
      r = LABEL_UNKNOWN;
      if (!unk) begin
         case (cls)
            3'd0: r = 3'd1;
            3'd1: r = 3'd2;
            3'd2: r = 3'd3;
            3'd3: r = 3'd4;
            3'd4: r = 3'd6;
            default: r = LABEL_UNKNOWN;
         endcase
      end
      return r;
   endfunction
endpackage

// File: hdl/fvc_if.sv
// ----------------------------------------------------------------------------
// fvc_req_if / fvc_rsp_if: valid-ready channels of the classifier
// Request carries opcode and operands, response carries label and votes.
// ----------------------------------------------------------------------------
interface fvc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [6:0]  tree_sel;
   logic [8:0]  node_addr;
   logic        node_is_leaf;
   logic [2:0]  feature_sel;
   logic signed [31:0] data_value;
   logic [8:0]  left_next;
   logic [8:0]  right_next;
   logic [2:0]  leaf_class;
   logic        apply_correction;
   logic signed [31:0] track_height;
   logic [30:0] track_speed;
   modport source (output valid, opcode, tree_sel, node_addr, node_is_leaf, feature_sel,
                   data_value, left_next, right_next, leaf_class, apply_correction,
                   track_height, track_speed, input ready);
   modport sink (input valid, opcode, tree_sel, node_addr, node_is_leaf, feature_sel,
                 data_value, left_next, right_next, leaf_class, apply_correction,
                 track_height, track_speed, output ready);
endinterface

interface fvc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] class_label;
   logic [7:0] top_votes;
   modport source (output valid, class_label, top_votes, input ready);
   modport sink (input valid, class_label, top_votes, output ready);
endinterface

// File: hdl/fvc_ram.sv
// ----------------------------------------------------------------------------
// fvc_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// File: hdl/fvc_walker.sv
// ----------------------------------------------------------------------------
// fvc_walker: tree walk sequencer over the node memory
// Walk all trees node by node, count votes, pick the winner.
// ----------------------------------------------------------------------------
module fvc_walker import fvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [8:0]  size_rd,
   input  logic [31:0] feats [FEATURE_COUNT],
   input  node_type    node_rd,
   output logic [TREE_W-1:0] size_addr,
   output logic        rd_en,
   output logic [STORE_AW-1:0] rd_addr,
   output logic        done,
   output logic [2:0]  best,
   output logic [7:0]  maxv
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TREE = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_MAX  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [TREE_W-1:0] tree_ff, tree_in;
   logic [NODE_W-1:0] idx_ff, idx_in;
   logic [8:0]        steps_ff, steps_in;
   logic [7:0]        votes_ff [CLASS_COUNT];
   logic [7:0]        maxv_ff, maxv_in;
   logic [2:0]        best_ff, best_in;
   logic [2:0]        cidx_ff, cidx_in;
   logic              vote_en;
   logic [2:0]        vote_cls;
   logic [8:0]        size;
   logic [8:0]        nxt;
   logic [2:0]        fsel;

   // size memory is addressed by the current tree; data is valid from S_WAIT on
   assign size_addr = tree_ff;
   assign size = size_rd;
   assign fsel = node_rd.feat;

   always_comb begin
      state_in = state_ff; tree_in = tree_ff; idx_in = idx_ff; steps_in = steps_ff;
      maxv_in = maxv_ff; best_in = best_ff; cidx_in = cidx_ff;
      vote_en = 1'b0; vote_cls = 3'd0; rd_en = 1'b0; nxt = 9'd0;
      rd_addr = STORE_AW'(32'(tree_ff) * MAX_NODES + 32'(idx_ff));
      unique case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_TREE; tree_in = '0;
         end
         S_TREE: begin
            idx_in = '0; steps_in = '0;
            rd_addr = STORE_AW'(32'(tree_ff) * MAX_NODES);
            rd_en = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: begin
            // an empty tree votes class zero
            if (size == 9'd0) begin
               vote_en = 1'b1;
               if (32'(tree_ff) == NUM_TREES - 1) begin
                  state_in = S_MAX; cidx_in = '0; maxv_in = '0; best_in = '0;
               end else state_in = S_TREE;
               tree_in = tree_ff + 1'b1;
            end else state_in = S_EVAL;
         end
         S_EVAL: begin
            nxt = ($signed(feats[fsel < FEATURE_COUNT ? fsel : 3'd0]) <=
                   $signed(node_rd.thr)) ? node_rd.left : node_rd.right;
            if (node_rd.leaf || 32'(steps_ff) >= MAX_NODES || 32'(fsel) >= FEATURE_COUNT
                || nxt >= size) begin
               vote_en = 1'b1;
               if (node_rd.leaf && 32'(node_rd.cls) < CLASS_COUNT) vote_cls = node_rd.cls;
               if (32'(tree_ff) == NUM_TREES - 1) begin
                  state_in = S_MAX; cidx_in = '0; maxv_in = '0; best_in = '0;
               end else state_in = S_TREE;
               tree_in = tree_ff + 1'b1;
            end else begin
               steps_in = steps_ff + 1'b1;
               idx_in = nxt[NODE_W-1:0];
               rd_addr = STORE_AW'(32'(tree_ff) * MAX_NODES + 32'(nxt[NODE_W-1:0]));
               rd_en = 1'b1; state_in = S_WAIT;
            end
         end
         S_MAX: begin
            if (votes_ff[cidx_ff] > maxv_ff) begin
               maxv_in = votes_ff[cidx_ff]; best_in = cidx_ff;
            end
            cidx_in = cidx_ff + 1'b1;
            if (32'(cidx_ff) == CLASS_COUNT - 1) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < CLASS_COUNT; i++) votes_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (start && state_ff == S_IDLE)
            for (int i = 0; i < CLASS_COUNT; i++) votes_ff[i] <= '0;
         else if (vote_en) votes_ff[vote_cls] <= votes_ff[vote_cls] + 1'b1;
      end
      tree_ff <= tree_in; idx_ff <= idx_in; steps_ff <= steps_in;
      maxv_ff <= maxv_in; best_ff <= best_in; cidx_ff <= cidx_in;
   end

   assign done = (state_ff == S_MAX) && (32'(cidx_ff) == CLASS_COUNT - 1);
   assign best = best_in;
   assign maxv = maxv_in;
endmodule

// File: hdl/fvc_post.sv
// ----------------------------------------------------------------------------
// fvc_post: correction rules, vote gating and label mapping
// Pure logic on the winning class; registered by the top level.
// ----------------------------------------------------------------------------
module fvc_post import fvc_pkg::*; (
   input  cfg_type    cfg,
   input  track_type  trk,
   input  logic [2:0] best,
   input  logic [7:0] maxv,
   output logic [2:0] label
);
   logic signed [32:0] h, low, high, ground;
   logic [30:0] slow, fast;
   logic [2:0] b;
   logic unk;

   always_comb begin
      h = {trk.height[31], trk.height};
      low = {5'd0, cfg.low_h, 16'd0};
      high = {5'd0, cfg.high_h, 16'd0};
      ground = {5'd0, cfg.ground_h, 16'd0};
      slow = {5'd0, cfg.slow_v, 16'd0};
      fast = {5'd0, cfg.fast_v, 16'd0};
      b = best; unk = 1'b0;
      if (trk.corr) begin
         if (h < low) begin
            if (b == 3'd4) b = 3'd1;
            if (b == 3'd0 && trk.speed > slow) b = 3'd1;
            if (b == 3'd2) begin
               if (h < 0) b = 3'd1;
               else if (h < ground) unk = 1'b1;
            end
         end
         if (h > high && !unk) begin
            if (b == 3'd1) b = (trk.speed > fast) ? 3'd4 : 3'd3;
            if (b == 3'd0) b = 3'd3;
         end
      end
      if (!unk) begin
         if (b == 3'd2) unk = maxv < cfg.min_two;
         else if (b == 3'd3) unk = maxv < cfg.min_three;
         else unk = maxv < cfg.min_def;
      end else unk = unk | (maxv < cfg.min_def) | 1'b1;
      label = class_label(b, unk);
   end
endmodule

// File: hdl/forest_vote_classifier_top.sv
// ----------------------------------------------------------------------------
// forest_vote_classifier_top: random forest inference with majority vote
// Node memory, tree walker, correction rules and response register.
// ----------------------------------------------------------------------------
//   channel | direction | transaction
//   req     | in        | opcode plus node, count, feature or track operands
//   rsp     | out       | class_label, top_votes (classify only)
//   csr     | in        | register index and write data
//
// A classify starts the walk of each tree, then per node visited reads the
// registered node memory and compares; an empty tree ends after its count
// read. A vote scan over all classes follows; the node memory port limits
// the walk. Reset is synchronous, clears the features and control state and
// loads the config defaults; a clearing pass over every tree then zeroes the
// node count memory. The node memory is not cleared. While clearing, while a
// classify runs or while its response waits, req stalls.
module forest_vote_classifier_top import fvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fvc_req_if.sink     req,
   fvc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   cfg_type    cfg_ff;
   track_type  trk_ff;
   logic [31:0] feats_ff [FEATURE_COUNT];
   logic        busy_ff, rsp_valid_ff;
   logic        clr_busy_ff;
   logic [TREE_W-1:0] clr_ff;
   logic [2:0]  label_ff;
   logic [7:0]  votes_ff;
   logic        acc, start, wr_node, done, rd_en;
   logic        set_cnt, sz_we;
   logic [TREE_W-1:0] sz_addr, walk_sz_addr;
   logic [8:0]  sz_wdata, size_rd;
   logic [STORE_AW-1:0] rd_addr, mem_addr;
   node_type    node_rd, node_wr;
   logic [2:0]  best, label;
   logic [7:0]  maxv;

   // Hold off new requests while clearing, while a classify is walking or its
   // result waits.
   assign req.ready = !busy_ff && !rsp_valid_ff && !clr_busy_ff;
   assign acc = req.valid && req.ready;
   assign start = acc && req.opcode == OP_CLASSIFY;
   assign wr_node = acc && req.opcode == OP_WRITE_NODE &&
                    32'(req.tree_sel) < NUM_TREES && 32'(req.node_addr) < MAX_NODES;
   assign set_cnt = acc && req.opcode == OP_SET_COUNT && 32'(req.tree_sel) < NUM_TREES;

   assign node_wr = '{leaf: req.node_is_leaf, feat: req.feature_sel, thr: req.data_value,
                      left: req.left_next, right: req.right_next, cls: req.leaf_class};
   assign mem_addr = wr_node ?
      STORE_AW'(32'(req.tree_sel) * MAX_NODES + 32'(req.node_addr[NODE_W-1:0])) : rd_addr;

   // Node count memory: clearing pass, count writes (saturated), else walker reads
   assign sz_we = clr_busy_ff || set_cnt;
   assign sz_addr = clr_busy_ff ? clr_ff : set_cnt ? req.tree_sel : walk_sz_addr;
   assign sz_wdata = clr_busy_ff ? 9'd0 :
                     (32'(req.node_addr) > MAX_NODES) ? 9'(MAX_NODES) : req.node_addr;

   fvc_ram #(.WIDTH(NODE_BITS), .DEPTH(STORE_DEPTH)) u_nodes (
      .clock(clock), .we(wr_node), .addr(mem_addr), .wdata(node_wr), .rdata(node_rd));

   fvc_ram #(.WIDTH(9), .DEPTH(NUM_TREES)) u_sizes (
      .clock(clock), .we(sz_we), .addr(sz_addr), .wdata(sz_wdata), .rdata(size_rd));

   fvc_walker u_walk (
      .clock(clock), .reset(reset), .start(start), .size_rd(size_rd), .feats(feats_ff),
      .node_rd(node_rd), .size_addr(walk_sz_addr), .rd_en(rd_en), .rd_addr(rd_addr),
      .done(done), .best(best), .maxv(maxv));

   fvc_post u_post (.cfg(cfg_ff), .trk(trk_ff), .best(best), .maxv(maxv), .label(label));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         clr_busy_ff <= 1'b1; clr_ff <= '0;
         cfg_ff <= '{min_two: 8'd50, min_three: 8'd70, min_def: 8'd60, low_h: 12'd80,
                     high_h: 12'd300, slow_v: 10'd5, fast_v: 10'd25, ground_h: 12'd10};
         for (int i = 0; i < FEATURE_COUNT; i++) feats_ff[i] <= '0;
      end else begin
         // Advance the clearing pass one tree per cycle, drop it after the last
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == NUM_TREES - 1) clr_busy_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_MIN_TWO:   cfg_ff.min_two   <= csr_wdata[7:0];
               REG_MIN_THREE: cfg_ff.min_three <= csr_wdata[7:0];
               REG_MIN_DEF:   cfg_ff.min_def   <= csr_wdata[7:0];
               REG_LOW_H:     cfg_ff.low_h     <= csr_wdata;
               REG_HIGH_H:    cfg_ff.high_h    <= csr_wdata;
               REG_SLOW_V:    cfg_ff.slow_v    <= csr_wdata[9:0];
               REG_FAST_V:    cfg_ff.fast_v    <= csr_wdata[9:0];
               REG_GROUND_H:  cfg_ff.ground_h  <= csr_wdata;
               default: ;
            endcase
         end
         if (acc && req.opcode == OP_LOAD_FEAT && 32'(req.feature_sel) < FEATURE_COUNT)
            feats_ff[req.feature_sel] <= req.data_value;
         if (start) busy_ff <= 1'b1;
         else if (done) busy_ff <= 1'b0;
         // Raise the response on the last vote scan step, drop it once taken.
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (start) trk_ff <= '{corr: req.apply_correction, height: req.track_height,
                             speed: req.track_speed};
      if (done) begin
         label_ff <= label; votes_ff <= maxv;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.class_label = label_ff;
   assign rsp.top_votes = votes_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !acc) else $error("request taken during classify");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("classify done without start");
   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      wr_node |-> !rd_en) else $error("node write collides with walk read");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done)) else $error("response without classify");
endmodule
